[design/gpc_pkg.sv]
// Shared constants, types and helpers for the grid path counter core.
// No dependencies; used by gpc_cell and the top level core.
package gpc_pkg;

    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 512;
    localparam int COUNT_BITS  = 25;

    localparam int CFG_COUNT_BITS = 10;
    localparam int CFG_DATA_BITS  = 25;
    localparam int CFG_INDEX_BITS = 2;

    localparam int COL_POS_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_POS_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_CMP_BITS =
        (COL_POS_BITS + 1 > CFG_COUNT_BITS) ? COL_POS_BITS + 1 : CFG_COUNT_BITS;
    localparam int ROW_CMP_BITS =
        (ROW_POS_BITS + 1 > CFG_COUNT_BITS) ? ROW_POS_BITS + 1 : CFG_COUNT_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS      = 2'd2;

    localparam logic [CFG_COUNT_BITS-1:0] ROW_COUNT_RESET    = 10'd1;
    localparam logic [CFG_COUNT_BITS-1:0] COLUMN_COUNT_RESET = 10'd1;
    localparam logic [COUNT_BITS-1:0]     MODULUS_RESET      = COUNT_BITS'(20170805);

    localparam logic [1:0] KIND_FREE    = 2'd0;
    localparam logic [1:0] KIND_BLOCKED = 2'd1;
    localparam logic [1:0] KIND_NO_TURN = 2'd2;

    // per-cell control carried from the accept stage to the update stage
    typedef struct packed {
        logic [1:0]              kind;
        logic [COL_POS_BITS-1:0] col;
        logic                    first_row;
        logic                    first_col;
        logic                    grid_end;
        logic                    single;
        logic                    fwd;
    } cell_info_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] down;
        logic [COUNT_BITS-1:0] right;
        logic [COUNT_BITS-1:0] result;
    } cell_out_t;

    function automatic logic [COUNT_BITS-1:0] mod_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] b,
        input logic [COUNT_BITS-1:0] m
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[COUNT_BITS-1:0];
    endfunction

endpackage

[design/gpc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/gpc_cell.sv]
// Per-cell update: picks the incoming counts, applies the cell kind, reduces sums.
// Depends on gpc_pkg.
module gpc_cell (
    input  gpc_pkg::cell_info_t              info,
    input  logic [gpc_pkg::COUNT_BITS-1:0]   mem_above,
    input  logic [gpc_pkg::COUNT_BITS-1:0]   last_down,
    input  logic [gpc_pkg::COUNT_BITS-1:0]   left,
    input  logic [gpc_pkg::COUNT_BITS-1:0]   modulus,
    output gpc_pkg::cell_out_t               res
);

    logic [gpc_pkg::COUNT_BITS-1:0] from_above;
    logic [gpc_pkg::COUNT_BITS-1:0] from_left;
    logic [gpc_pkg::COUNT_BITS-1:0] sum;

    always_comb begin
        if (info.first_row && info.first_col) begin
            // start cell is entered once, moving down
            from_above = gpc_pkg::COUNT_BITS'(1);
            from_left  = '0;
        end else begin
            if (info.first_row) begin
                from_above = '0;
            end else if (info.fwd) begin
                from_above = last_down;
            end else begin
                from_above = mem_above;
            end
            from_left = info.first_col ? '0 : left;
        end

        sum = gpc_pkg::mod_add(from_above, from_left, modulus);

        case (info.kind)
            gpc_pkg::KIND_BLOCKED: begin
                res.down  = '0;
                res.right = '0;
            end
            gpc_pkg::KIND_NO_TURN: begin
                res.down  = from_above;
                res.right = from_left;
            end
            default: begin
                res.down  = sum;
                res.right = sum;
            end
        endcase

        if (info.single) begin
            res.result = gpc_pkg::COUNT_BITS'(1);
        end else if (info.kind == gpc_pkg::KIND_BLOCKED) begin
            res.result = '0;
        end else begin
            res.result = sum;
        end
    end

endmodule

[design/grid_path_count_no_turn_dp_core.sv]
// Top level of the grid path counter: config registers, raster position,
// accept and update stages around the column line buffer, result register.
// Depends on gpc_pkg, gpc_ram and gpc_cell.
//
//  channel | ports                              | role
//  --------+------------------------------------+---------------------------
//  s_      | s_valid s_ready s_cell_kind        | one grid cell per beat
//  m_      | m_valid m_ready m_path_count       | one count per finished grid
//  cfg_    | cfg_wr_en cfg_index cfg_wdata      | register writes, no wait
//
// One cell per cycle while s_ready is high. A cell is read from the column buffer at
// accept and updated and written back in the update stage; a cell in the same column
// as the one just ahead (one-column grids) takes the forwarded count instead. The
// last cell of a grid passes the update stage and the result register to m_valid.
// s_ready drops only while a finished count waits and the next grid end is ready.
// Synchronous active-low reset clears control state; the buffer is not cleared.
module grid_path_count_no_turn_dp_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_cell_kind,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gpc_pkg::COUNT_BITS-1:0]      m_path_count,
    input  logic                                cfg_wr_en,
    input  logic [gpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [gpc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    localparam int CB = gpc_pkg::COUNT_BITS;
    localparam int CPB = gpc_pkg::COL_POS_BITS;
    localparam int RPB = gpc_pkg::ROW_POS_BITS;

    // configuration
    logic [gpc_pkg::CFG_COUNT_BITS-1:0] row_count_reg, row_count_next;
    logic [gpc_pkg::CFG_COUNT_BITS-1:0] column_count_reg, column_count_next;
    logic [CB-1:0]                      modulus_reg, modulus_next;

    // raster position of the next cell
    logic [RPB-1:0] row_pos_reg, row_pos_next;
    logic [CPB-1:0] col_pos_reg, col_pos_next;

    // update stage
    logic                 s1_valid_reg, s1_valid_next;
    gpc_pkg::cell_info_t  s1_info_reg, s1_info_next;
    logic [CB-1:0]        left_reg, left_next;
    logic [CB-1:0]        last_down_reg, last_down_next;

    // result register
    logic          m_valid_reg, m_valid_next;
    logic [CB-1:0] m_count_reg, m_count_next;

    logic [gpc_pkg::ROW_CMP_BITS-1:0] rows_eff;
    logic [gpc_pkg::COL_CMP_BITS-1:0] cols_eff;
    logic                             row_end;
    logic                             grid_end;
    logic                             accept;
    logic                             s1_stall;
    logic                             s1_retire;
    logic [CB-1:0]                    mem_above;
    gpc_pkg::cell_out_t               cell_res;

    always_comb begin
        if (row_count_reg == '0) begin
            rows_eff = gpc_pkg::ROW_CMP_BITS'(1);
        end else if (gpc_pkg::ROW_CMP_BITS'(row_count_reg) >
                     gpc_pkg::ROW_CMP_BITS'(gpc_pkg::MAX_ROWS)) begin
            rows_eff = gpc_pkg::ROW_CMP_BITS'(gpc_pkg::MAX_ROWS);
        end else begin
            rows_eff = gpc_pkg::ROW_CMP_BITS'(row_count_reg);
        end
        if (column_count_reg == '0) begin
            cols_eff = gpc_pkg::COL_CMP_BITS'(1);
        end else if (gpc_pkg::COL_CMP_BITS'(column_count_reg) >
                     gpc_pkg::COL_CMP_BITS'(gpc_pkg::MAX_COLUMNS)) begin
            cols_eff = gpc_pkg::COL_CMP_BITS'(gpc_pkg::MAX_COLUMNS);
        end else begin
            cols_eff = gpc_pkg::COL_CMP_BITS'(column_count_reg);
        end
        row_end  = (gpc_pkg::COL_CMP_BITS'(col_pos_reg) + gpc_pkg::COL_CMP_BITS'(1))
                   >= cols_eff;
        grid_end = row_end &&
                   ((gpc_pkg::ROW_CMP_BITS'(row_pos_reg) + gpc_pkg::ROW_CMP_BITS'(1))
                   >= rows_eff);
    end

    assign s1_stall  = s1_valid_reg && s1_info_reg.grid_end && m_valid_reg && !m_ready;
    assign s1_retire = s1_valid_reg && !s1_stall;
    assign s_ready   = !s1_stall;
    assign accept    = s_valid && s_ready;

    gpc_ram #(
        .WIDTH (CB),
        .DEPTH (gpc_pkg::MAX_COLUMNS)
    ) u_column_buf (
        .aclk    (aclk),
        .wr_en   (s1_retire),
        .wr_addr (s1_info_reg.col),
        .wr_data (cell_res.down),
        .rd_en   (accept),
        .rd_addr (col_pos_reg),
        .rd_data (mem_above)
    );

    gpc_cell u_cell (
        .info      (s1_info_reg),
        .mem_above (mem_above),
        .last_down (last_down_reg),
        .left      (left_reg),
        .modulus   (modulus_reg),
        .res       (cell_res)
    );

    always_comb begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        modulus_next      = modulus_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                gpc_pkg::REG_ROW_COUNT:
                    row_count_next = cfg_wdata[gpc_pkg::CFG_COUNT_BITS-1:0];
                gpc_pkg::REG_COLUMN_COUNT:
                    column_count_next = cfg_wdata[gpc_pkg::CFG_COUNT_BITS-1:0];
                gpc_pkg::REG_MODULUS:
                    modulus_next = cfg_wdata[CB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        row_pos_next   = row_pos_reg;
        col_pos_next   = col_pos_reg;
        s1_valid_next  = s1_valid_reg;
        s1_info_next   = s1_info_reg;
        left_next      = left_reg;
        last_down_next = last_down_reg;
        m_valid_next   = m_valid_reg;
        m_count_next   = m_count_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s1_retire) begin
            s1_valid_next  = 1'b0;
            last_down_next = cell_res.down;
            left_next      = s1_info_reg.grid_end ? '0 : cell_res.right;
            if (s1_info_reg.grid_end) begin
                m_valid_next = 1'b1;
                m_count_next = cell_res.result;
            end
        end

        if (accept) begin
            s1_valid_next          = 1'b1;
            s1_info_next.kind      = s_cell_kind;
            s1_info_next.col       = col_pos_reg;
            s1_info_next.first_row = (row_pos_reg == '0);
            s1_info_next.first_col = (col_pos_reg == '0);
            s1_info_next.grid_end  = grid_end;
            s1_info_next.single    = (rows_eff == gpc_pkg::ROW_CMP_BITS'(1)) &&
                                     (cols_eff == gpc_pkg::COL_CMP_BITS'(1));
            // the cell ahead writes this column at the same edge
            s1_info_next.fwd       = s1_valid_reg && (s1_info_reg.col == col_pos_reg);
            if (grid_end) begin
                row_pos_next = '0;
                col_pos_next = '0;
            end else if (row_end) begin
                row_pos_next = row_pos_reg + RPB'(1);
                col_pos_next = '0;
            end else begin
                col_pos_next = col_pos_reg + CPB'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= gpc_pkg::ROW_COUNT_RESET;
            column_count_reg <= gpc_pkg::COLUMN_COUNT_RESET;
            modulus_reg      <= gpc_pkg::MODULUS_RESET;
            row_pos_reg      <= '0;
            col_pos_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            left_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            modulus_reg      <= modulus_next;
            row_pos_reg      <= row_pos_next;
            col_pos_reg      <= col_pos_next;
            s1_valid_reg     <= s1_valid_next;
            left_reg         <= left_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_info_reg   <= s1_info_next;
        last_down_reg <= last_down_next;
        m_count_reg   <= m_count_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_path_count = m_count_reg;

endmodule
